### hdl/cau_pkg.sv
// Package for the complex arithmetic unit: word format, command codes,
// beat structs and derived datapath widths. No dependencies.
`default_nettype none
package cau_pkg;

	// Q format of every operand and result part
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Datapath widths derived from the word format
	localparam int PROD_BITS = 2 * WORD_BITS;          // magnitude product
	localparam int SUM_BITS  = 2 * WORD_BITS + 2;      // signed sum of two products
	localparam int MAG_BITS  = 2 * WORD_BITS + 1;      // magnitude of that sum
	localparam int DEN_BITS  = 2 * WORD_BITS;          // |b|^2
	localparam int NUM_BITS  = MAG_BITS + FRAC_BITS;   // scaled dividend
	localparam int QUO_BITS  = WORD_BITS + 1;          // quotient bits kept
	localparam int CMP_BITS  = (NUM_BITS > DEN_BITS + QUO_BITS) ?
		NUM_BITS : DEN_BITS + QUO_BITS;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                          command;
		logic signed [WORD_BITS-1:0]   a_re;
		logic signed [WORD_BITS-1:0]   a_im;
		logic signed [WORD_BITS-1:0]   b_re;
		logic signed [WORD_BITS-1:0]   b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0]   result_re;
		logic signed [WORD_BITS-1:0]   result_im;
		logic                          divide_by_zero;
		logic                          overflowed;
	} cau_out_t;

endpackage
`default_nettype wire

### hdl/complex_arithmetic_unit_top.sv
// Complex add / subtract / multiply / divide on signed Q16.16 parts,
// fully pipelined. Depends on cau_pkg.
//
//  channel | signals                      | beat
//  --------+------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_data  | command and operands a, b
//  out     | out_valid, out_ready, out_data| result parts and status flags
//
// One beat enters per cycle unless the output stalls; stages: five arithmetic,
// one restoring-division stage per quotient bit (33), and the output register.
// All stages advance together whenever the output register is empty or taken;
// a stalled output freezes the whole pipe, nothing is dropped or repeated.
// Reset clears the stage valid bits only.
`default_nettype none
module complex_arithmetic_unit_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cau_pkg::cau_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cau_pkg::cau_out_t out_data
);
	import cau_pkg::*;

	typedef struct packed {
		logic [NUM_BITS-1:0] rem;   // division remainder, or passed-through value
		logic [QUO_BITS-1:0] quo;
		logic                big;   // quotient beyond the kept bits
		logic                neg;
	} lane_t;

	typedef struct packed {
		logic                vld;
		logic                isdiv;
		logic                dz;
		logic [DEN_BITS-1:0] den;
		lane_t [1:0]         ln;    // 0 real, 1 imaginary
	} dstage_t;

	localparam logic [MAG_BITS-1:0] POS_LIM = {{(MAG_BITS-WORD_BITS+1){1'b0}},
		{(WORD_BITS-1){1'b1}}};
	localparam logic [MAG_BITS-1:0] NEG_LIM = POS_LIM + MAG_BITS'(1);
	localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: operand magnitudes and signs (0 a_re, 1 a_im, 2 b_re, 3 b_im)
	logic                        v_s1;
	cmd_t                        cmd_s1;
	logic [3:0][WORD_BITS-1:0]   opd_s1;
	logic [3:0][WORD_BITS-1:0]   mag_s1;
	logic [3:0]                  neg_s1;
	logic [3:0][WORD_BITS-1:0]   opd_in;

	assign opd_in[0] = in_data.a_re;
	assign opd_in[1] = in_data.a_im;
	assign opd_in[2] = in_data.b_re;
	assign opd_in[3] = in_data.b_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= in_data.command;
			for (int i = 0; i < 4; i++) begin
				opd_s1[i] <= opd_in[i];
				neg_s1[i] <= opd_in[i][WORD_BITS-1];
				mag_s1[i] <= opd_in[i][WORD_BITS-1] ? (~opd_in[i] + WORD_BITS'(1))
					: opd_in[i];
			end
		end
	end

	// stage 2: six magnitude products
	// 0 ar*br, 1 ai*bi, 2 ai*br, 3 ar*bi, 4 br*br, 5 bi*bi
	logic                        v_s2;
	cmd_t                        cmd_s2;
	logic [3:0][WORD_BITS-1:0]   opd_s2;
	logic [5:0][PROD_BITS-1:0]   p_s2;
	logic [3:0]                  psg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2    <= cmd_s1;
			opd_s2    <= opd_s1;
			p_s2[0]   <= PROD_BITS'(mag_s1[0]) * PROD_BITS'(mag_s1[2]);
			p_s2[1]   <= PROD_BITS'(mag_s1[1]) * PROD_BITS'(mag_s1[3]);
			p_s2[2]   <= PROD_BITS'(mag_s1[1]) * PROD_BITS'(mag_s1[2]);
			p_s2[3]   <= PROD_BITS'(mag_s1[0]) * PROD_BITS'(mag_s1[3]);
			p_s2[4]   <= PROD_BITS'(mag_s1[2]) * PROD_BITS'(mag_s1[2]);
			p_s2[5]   <= PROD_BITS'(mag_s1[3]) * PROD_BITS'(mag_s1[3]);
			psg_s2[0] <= neg_s1[0] ^ neg_s1[2];
			psg_s2[1] <= neg_s1[1] ^ neg_s1[3];
			psg_s2[2] <= neg_s1[1] ^ neg_s1[2];
			psg_s2[3] <= neg_s1[0] ^ neg_s1[3];
		end
	end

	// stage 3: exact signed sums per command, divisor magnitude squared
	logic                              v_s3;
	cmd_t                              cmd_s3;
	logic                              dz_s3;
	logic [DEN_BITS-1:0]               den_s3;
	logic signed [1:0][SUM_BITS-1:0]   sum_s3;

	logic signed [PROD_BITS:0]   sp [4];
	logic signed [SUM_BITS-1:0]  sx [4];
	logic signed [SUM_BITS-1:0]  ox [4];
	logic signed [SUM_BITS-1:0]  re_c, im_c;
	logic [DEN_BITS-1:0]         den_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sp[i] = psg_s2[i] ? -$signed({1'b0, p_s2[i]}) : $signed({1'b0, p_s2[i]});
			sx[i] = SUM_BITS'(sp[i]);
			ox[i] = SUM_BITS'($signed(opd_s2[i]));
		end
		den_c = p_s2[4] + p_s2[5];
		unique case (cmd_s2)
			CMD_ADD: begin
				re_c = ox[0] + ox[2];
				im_c = ox[1] + ox[3];
			end
			CMD_SUB: begin
				re_c = ox[0] - ox[2];
				im_c = ox[1] - ox[3];
			end
			CMD_MUL: begin
				re_c = sx[0] - sx[1];
				im_c = sx[2] + sx[3];
			end
			default: begin
				re_c = sx[0] + sx[1];
				im_c = sx[2] - sx[3];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3    <= cmd_s2;
			den_s3    <= den_c;
			dz_s3     <= (cmd_s2 == CMD_DIV) && (den_c == '0);
			sum_s3[0] <= re_c;
			sum_s3[1] <= im_c;
		end
	end

	// stage 4: sign and magnitude of each part
	logic                             v_s4;
	cmd_t                             cmd_s4;
	logic                             dz_s4;
	logic [DEN_BITS-1:0]              den_s4;
	logic [1:0][MAG_BITS-1:0]         mag_s4;
	logic [1:0]                       neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4 <= cmd_s3;
			dz_s4  <= dz_s3;
			den_s4 <= den_s3;
			for (int p = 0; p < 2; p++) begin
				neg_s4[p] <= sum_s3[p][SUM_BITS-1];
				mag_s4[p] <= sum_s3[p][SUM_BITS-1] ? MAG_BITS'(-sum_s3[p])
					: MAG_BITS'(sum_s3[p]);
			end
		end
	end

	// stage 5: scale the dividend and check quotient range; others pass through, products shifted down by FRAC_BITS
	dstage_t dst_s [QUO_BITS+1];
	dstage_t dst_in;

	always_comb begin
		dst_in.vld   = v_s4;
		dst_in.isdiv = (cmd_s4 == CMD_DIV) && !dz_s4;
		dst_in.dz    = dz_s4;
		dst_in.den   = den_s4;
		for (int p = 0; p < 2; p++) begin
			dst_in.ln[p].neg = neg_s4[p];
			dst_in.ln[p].quo = '0;
			if (cmd_s4 == CMD_DIV) begin
				dst_in.ln[p].rem = {mag_s4[p], {FRAC_BITS{1'b0}}};
				dst_in.ln[p].big = CMP_BITS'({mag_s4[p], {FRAC_BITS{1'b0}}}) >=
					CMP_BITS'({den_s4, {QUO_BITS{1'b0}}});
			end else begin
				dst_in.ln[p].rem = (cmd_s4 == CMD_MUL) ? NUM_BITS'(mag_s4[p] >> FRAC_BITS)
					: NUM_BITS'(mag_s4[p]);
				dst_in.ln[p].big = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s[0].vld <= 1'b0;
		end else if (adv) begin
			dst_s[0] <= dst_in;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		localparam int BIT = QUO_BITS - 1 - k;
		dstage_t nxt;
		logic [CMP_BITS-1:0] sub;

		always_comb begin
			nxt = dst_s[k];
			sub = CMP_BITS'(dst_s[k].den) << BIT;
			for (int p = 0; p < 2; p++) begin
				if (dst_s[k].isdiv && !dst_s[k].ln[p].big &&
					(CMP_BITS'(dst_s[k].ln[p].rem) >= sub)) begin
					nxt.ln[p].rem      = dst_s[k].ln[p].rem - sub[NUM_BITS-1:0];
					nxt.ln[p].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dst_s[k+1].vld <= 1'b0;
			end else if (adv) begin
				dst_s[k+1] <= nxt;
			end
		end
	end

	// output: round-toward-zero magnitude back to two's complement, saturated
	cau_out_t            res_c;
	logic [MAG_BITS-1:0] fm [2];
	logic [WORD_BITS-1:0] pw [2];
	logic [1:0]          ovp;

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			fm[p]  = dst_s[QUO_BITS].isdiv ? MAG_BITS'(dst_s[QUO_BITS].ln[p].quo)
				: dst_s[QUO_BITS].ln[p].rem[MAG_BITS-1:0];
			ovp[p] = 1'b0;
			if (!dst_s[QUO_BITS].ln[p].big && fm[p] == '0) begin
				pw[p] = '0;
			end else if (!dst_s[QUO_BITS].ln[p].neg) begin
				if (dst_s[QUO_BITS].ln[p].big || fm[p] > POS_LIM) begin
					pw[p]  = W_MAX;
					ovp[p] = 1'b1;
				end else begin
					pw[p] = fm[p][WORD_BITS-1:0];
				end
			end else begin
				if (dst_s[QUO_BITS].ln[p].big || fm[p] > NEG_LIM) begin
					pw[p]  = W_MIN;
					ovp[p] = 1'b1;
				end else begin
					pw[p] = ~fm[p][WORD_BITS-1:0] + WORD_BITS'(1);
				end
			end
		end
		if (dst_s[QUO_BITS].dz) begin
			res_c.result_re      = '0;
			res_c.result_im      = '0;
			res_c.divide_by_zero = 1'b1;
			res_c.overflowed     = 1'b0;
		end else begin
			res_c.result_re      = pw[0];
			res_c.result_im      = pw[1];
			res_c.divide_by_zero = 1'b0;
			res_c.overflowed     = |ovp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dst_s[QUO_BITS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res_c;
		end
	end

`ifndef SYNTHESIS
	// a zero divisor never reports a value or an overflow
	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |->
		out_data.result_re == '0 && out_data.result_im == '0 && !out_data.overflowed)
		else $error("divide-by-zero beat carries data");

	// an overflow always lands on a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflowed |->
		out_data.result_re == W_MAX || out_data.result_re == W_MIN ||
		out_data.result_im == W_MAX || out_data.result_im == W_MIN)
		else $error("overflow flag without saturated part");

	// a stalled output freezes the front stages
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
